// ===== design/crd_pkg.sv =====
// Package with the widths and limits shared by the camera ray direction pipeline.
package crd_pkg;

  localparam int COMP_BITS = 16;
  localparam int LANES     = 3;
  localparam int VEC_BITS  = LANES * COMP_BITS;
  localparam int POS_BITS  = 16;
  localparam int PROD_BITS = POS_BITS + 1 + COMP_BITS;
  localparam int ACC_BITS  = COMP_BITS + POS_BITS + 4;
  localparam int RND_BITS  = ACC_BITS - POS_BITS;
  localparam int SQ_BITS   = 2 * COMP_BITS;
  localparam int QUO_BITS  = 31;
  localparam int ROOT_BITS = 16;
  localparam int OUT_BITS  = 16;
  localparam int DATA_IN_BITS  = 2 * POS_BITS;
  localparam int DATA_OUT_BITS = ((LANES * OUT_BITS + 7) / 8) * 8;

  localparam logic signed [RND_BITS-1:0] SAT_MAX =
    RND_BITS'((64'sd1 <<< (COMP_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_BITS-1:0] SAT_MIN =
    RND_BITS'(-(64'sd1 <<< (COMP_BITS - 1)));

  typedef enum logic [1:0] {
    REG_CORNER = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_UP     = 2'd2
  } cfg_reg_t;

endpackage

// ===== design/camera_ray_direction.sv =====
// Top level of the camera ray direction pipeline.
//
// Each input beat carries a screen position and yields one output beat with the unit ray
// direction in Q1.14. A new beat is taken every cycle unless the output stalls. Four stages
// form the saturated direction and its squared length, 31 stages divide the squared component
// by the squared length one quotient bit a stage, and 16 stages take the integer square root
// one root bit a stage before the rounded, signed result is registered. The whole pipeline
// holds while the output beat is not taken. Configuration writes are meant for idle times.
module camera_ray_direction
  import crd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [DATA_IN_BITS-1:0]  s_tdata,  // x_pos, y_pos
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [DATA_OUT_BITS-1:0] m_tdata,  // dir_x, dir_y, dir_z
  output logic                     m_tuser,  // zero_length
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [VEC_BITS-1:0]      cfg_data
);

  logic [VEC_BITS-1:0] corner_vec;
  logic [VEC_BITS-1:0] right_vec;
  logic [VEC_BITS-1:0] up_vec;
  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_vec <= '0;
      right_vec  <= '0;
      up_vec     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CORNER: corner_vec <= cfg_data;
        REG_RIGHT:  right_vec  <= cfg_data;
        REG_UP:     up_vec     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Products.
  logic                        a_vld;
  logic signed [COMP_BITS-1:0] a_c  [LANES];
  logic signed [PROD_BITS-1:0] a_px [LANES];
  logic signed [PROD_BITS-1:0] a_py [LANES];
  logic signed [POS_BITS:0]    xs, ys;

  assign xs = $signed({1'b0, s_tdata[POS_BITS-1:0]});
  assign ys = $signed({1'b0, s_tdata[2*POS_BITS-1:POS_BITS]});

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < LANES; j++) begin
        a_c[j]  <= $signed(corner_vec[j*COMP_BITS +: COMP_BITS]);
        a_px[j] <= PROD_BITS'(xs * $signed(right_vec[j*COMP_BITS +: COMP_BITS]));
        a_py[j] <= PROD_BITS'(ys * $signed(up_vec[j*COMP_BITS +: COMP_BITS]));
      end
    end
  end

  // Sum, round and saturate.
  logic                 b_vld;
  logic [LANES-1:0]     b_neg;
  logic [COMP_BITS-1:0] b_mag [LANES];
  logic signed [ACC_BITS-1:0]  acc  [LANES];
  logic signed [RND_BITS-1:0]  rnd  [LANES];
  logic signed [COMP_BITS-1:0] sat  [LANES];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      acc[j] = ACC_BITS'($signed({a_c[j], {POS_BITS{1'b0}}})) + ACC_BITS'(a_px[j])
             + ACC_BITS'(a_py[j]) + ACC_BITS'(1 << (POS_BITS - 1));
      rnd[j] = acc[j][ACC_BITS-1:POS_BITS];
      if (rnd[j] > SAT_MAX) sat[j] = COMP_BITS'(SAT_MAX);
      else if (rnd[j] < SAT_MIN) sat[j] = COMP_BITS'(SAT_MIN);
      else sat[j] = COMP_BITS'(rnd[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < LANES; j++) begin
        b_neg[j] <= sat[j][COMP_BITS-1];
        b_mag[j] <= sat[j][COMP_BITS-1] ? COMP_BITS'(-sat[j]) : COMP_BITS'(sat[j]);
      end
    end
  end

  // Squares.
  logic               c_vld;
  logic [LANES-1:0]   c_neg;
  logic [SQ_BITS-1:0] c_sq [LANES];

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg <= b_neg;
      for (int j = 0; j < LANES; j++) c_sq[j] <= b_mag[j] * b_mag[j];
    end
  end

  // Squared length, then the divider stages. Index 0 is the length stage.
  logic               dv_vld  [0:QUO_BITS];
  logic               dv_zero [0:QUO_BITS];
  logic [LANES-1:0]   dv_neg  [0:QUO_BITS];
  logic [SQ_BITS-1:0] dv_s    [0:QUO_BITS];
  logic [SQ_BITS-1:0] dv_rem  [0:QUO_BITS][LANES];
  logic [QUO_BITS-1:0] dv_quo [0:QUO_BITS][LANES];
  logic [SQ_BITS+1:0] len_sum;

  assign len_sum = (SQ_BITS+2)'(c_sq[0]) + (SQ_BITS+2)'(c_sq[1]) + (SQ_BITS+2)'(c_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_neg[0]  <= c_neg;
      dv_s[0]    <= len_sum[SQ_BITS-1:0];
      dv_zero[0] <= (len_sum == '0);
      for (int j = 0; j < LANES; j++) begin
        dv_rem[0][j] <= c_sq[j];
        dv_quo[0][j] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [SQ_BITS:0] rin  [LANES];
    logic [SQ_BITS:0] diff [LANES];
    logic [LANES-1:0] ge;

    always_comb begin
      for (int j = 0; j < LANES; j++) begin
        if (k == 0) rin[j] = {1'b0, dv_rem[k][j]};
        else rin[j] = {dv_rem[k][j], 1'b0};
        ge[j]   = rin[j] >= {1'b0, dv_s[k]};
        diff[j] = rin[j] - {1'b0, dv_s[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (adv) dv_vld[k+1] <= dv_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_s[k+1]    <= dv_s[k];
        for (int j = 0; j < LANES; j++) begin
          dv_rem[k+1][j] <= ge[j] ? diff[j][SQ_BITS-1:0] : rin[j][SQ_BITS-1:0];
          dv_quo[k+1][j] <= {dv_quo[k][j][QUO_BITS-2:0], ge[j]};
        end
      end
    end
  end

  // Integer square root, one root bit a stage.
  logic                sr_vld  [1:ROOT_BITS];
  logic                sr_zero [1:ROOT_BITS];
  logic [LANES-1:0]    sr_neg  [1:ROOT_BITS];
  logic [QUO_BITS:0]   sr_op   [1:ROOT_BITS][LANES];
  logic [QUO_BITS:0]   sr_res  [1:ROOT_BITS][LANES];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    logic [QUO_BITS:0] op_in  [LANES];
    logic [QUO_BITS:0] res_in [LANES];
    logic [QUO_BITS:0] trial  [LANES];
    logic              v_in, z_in;
    logic [LANES-1:0]  n_in;
    logic [QUO_BITS:0] one;

    assign one = (QUO_BITS+1)'(1) << (2 * (ROOT_BITS - 1 - k));

    if (k == 0) begin : g_head
      always_comb begin
        v_in = dv_vld[QUO_BITS];
        z_in = dv_zero[QUO_BITS];
        n_in = dv_neg[QUO_BITS];
        for (int j = 0; j < LANES; j++) begin
          op_in[j]  = {1'b0, dv_quo[QUO_BITS][j]};
          res_in[j] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        v_in = sr_vld[k];
        z_in = sr_zero[k];
        n_in = sr_neg[k];
        for (int j = 0; j < LANES; j++) begin
          op_in[j]  = sr_op[k][j];
          res_in[j] = sr_res[k][j];
        end
      end
    end

    always_comb begin
      for (int j = 0; j < LANES; j++) trial[j] = res_in[j] + one;
    end

    always_ff @(posedge clk) begin
      if (rst) sr_vld[k+1] <= 1'b0;
      else if (adv) sr_vld[k+1] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_zero[k+1] <= z_in;
        sr_neg[k+1]  <= n_in;
        for (int j = 0; j < LANES; j++) begin
          if (op_in[j] >= trial[j]) begin
            sr_op[k+1][j]  <= op_in[j] - trial[j];
            sr_res[k+1][j] <= (res_in[j] >> 1) + one;
          end else begin
            sr_op[k+1][j]  <= op_in[j];
            sr_res[k+1][j] <= res_in[j] >> 1;
          end
        end
      end
    end
  end

  // Round, sign and output register.
  logic [ROOT_BITS:0]  rq  [LANES];
  logic [OUT_BITS-1:0] dir [LANES];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rq[j] = ((ROOT_BITS+1)'(sr_res[ROOT_BITS][j][ROOT_BITS-1:0]) + 1'b1) >> 1;
      if (sr_zero[ROOT_BITS]) dir[j] = '0;
      else if (sr_neg[ROOT_BITS][j]) dir[j] = OUT_BITS'(-rq[j]);
      else dir[j] = OUT_BITS'(rq[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= sr_vld[ROOT_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= DATA_OUT_BITS'({dir[2], dir[1], dir[0]});
      m_tuser <= sr_zero[ROOT_BITS];
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_gives_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("Zero-length beat carries a nonzero direction.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("Input taken while the output beat is stalled.");

  a_unit_bound_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384)
    else $error("Direction x exceeds unit magnitude.");

  a_unit_bound_z: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384)
    else $error("Direction z exceeds unit magnitude.");
`endif

endmodule

// ===== tb/sv/camera_ray_direction_tb.sv =====
// Self-checking testbench for the camera ray direction pipeline with a built-in predictor.
`timescale 1ns / 1ps
module camera_ray_direction_tb;
  import crd_pkg::*;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic zero_len;
  } ray_t;

  typedef struct {
    logic [15:0] xp;
    logic [15:0] yp;
    logic        chk;
    ray_t        fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_OUT_BITS-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [VEC_BITS-1:0] cfg_data = '0;

  logic [47:0] corner_q, right_q, up_q;
  ray_t expected_rays[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sending_done = 0;
  bit hold_off = 0;
  localparam int WATCHDOG = 20000;

  camera_ray_direction dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint comp_of(logic [47:0] v, int j);
    logic signed [15:0] c;
    c = v[j*16 +: 16];
    return longint'(c);
  endfunction

  function automatic longint unit_scale(longint m, longint s);
    longint lo, hi, mid;
    logic [127:0] lhs, rhs;
    lo = 0;
    hi = 32768;
    rhs = 128'(m * m) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 128'(mid * mid) * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (lo + 1) >> 1;
  endfunction

  function automatic ray_t trace_ray(logic [15:0] xp, logic [15:0] yp);
    longint d[3], mag[3], s, acc, r, q;
    ray_t res;
    logic signed [15:0] o[3];
    s = 0;
    for (int j = 0; j < 3; j++) begin
      acc = comp_of(corner_q, j) * 65536 + longint'(xp) * comp_of(right_q, j)
          + longint'(yp) * comp_of(up_q, j) + 32768;
      r = (acc >= 0) ? acc / 65536 : -((-acc + 65535) / 65536);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      d[j] = r;
      mag[j] = (r < 0) ? -r : r;
      s += mag[j] * mag[j];
    end
    if (s == 0) begin
      res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      return res;
    end
    for (int j = 0; j < 3; j++) begin
      q = (mag[j] == 0) ? 0 : unit_scale(mag[j], s);
      o[j] = 16'((d[j] < 0) ? -q : q);
    end
    res = '{o[0], o[1], o[2], 1'b0};
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CORNER: corner_q = v;
      REG_RIGHT:  right_q = v;
      default:    up_q = v;
    endcase
  endtask

  task automatic send_position(logic [15:0] xp, logic [15:0] yp, ray_t want);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yp, xp};
    expected_rays.push_back(want);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_rays.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [47:0] rand_vec(int mode);
    logic [47:0] v;
    for (int j = 0; j < 3; j++) begin
      case (mode)
        0: v[j*16 +: 16] = 16'($urandom);
        1: v[j*16 +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
        default: v[j*16 +: 16] = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      endcase
    end
    return v;
  endfunction

  // Receiver side: a random pause before each beat, and no beats while held off.
  always begin : receiver
    int pause;
    pause = $urandom_range(0, 4);
    if (pause > 0) begin
      m_tready <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    if (rst || hold_off) begin
      m_tready <= 1'b0;
      while (rst || hold_off) @(negedge clk);
    end
    m_tready <= 1'b1;
    @(posedge clk);
    while (!m_tvalid) @(posedge clk);
    @(negedge clk);
  end

  always @(posedge clk) begin
    ray_t want;
    ray_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
      if (expected_rays.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_rays.pop_front();
        if (got.dx !== want.dx) report_mismatch("dir_x", got.dx, want.dx);
        if (got.dy !== want.dy) report_mismatch("dir_y", got.dy, want.dy);
        if (got.dz !== want.dz) report_mismatch("dir_z", got.dz, want.dz);
        if (got.zero_len !== want.zero_len)
          report_mismatch("zero_length", got.zero_len, want.zero_len);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    wait (sending_done == 0 && !rst && expected_rays.size() > 10);
    hold_off = 1;
    for (stall = 0; stall < 200; stall++) @(negedge clk);
    hold_off = 0;
  end

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    ray_t want;
    corner_q = '0;
    right_q = '0;
    up_q = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers at reset: every ray is the zero vector.
    rows.push_back('{16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 1'b1}});
    rows.push_back('{16'hffff, 16'hffff, 1'b1, '{0, 0, 0, 1'b1}});
    foreach (rows[i]) send_position(rows[i].xp, rows[i].yp, rows[i].fixed);
    drain();

    // Corner straight down +z, steps zero: direction is +z exactly.
    write_reg(REG_CORNER, {16'h1000, 16'h0000, 16'h0000});
    rows.delete();
    rows.push_back('{16'h1234, 16'hfedc, 1'b1, '{0, 0, 16'sd16384, 1'b0}});
    write_reg(REG_RIGHT, '0);
    write_reg(REG_UP, '0);
    foreach (rows[i]) send_position(rows[i].xp, rows[i].yp, rows[i].fixed);
    drain();

    // Typical camera with position extremes, then saturating vectors.
    write_reg(REG_CORNER, {16'hf000, 16'h0800, 16'hf800});
    write_reg(REG_RIGHT, {16'h0000, 16'h0000, 16'h1000});
    write_reg(REG_UP, {16'h0000, 16'hf000, 16'h0000});
    rows.delete();
    foreach (rows[i]) ;
    for (int k = 0; k < 16; k++) begin
      row.xp = (k & 1) ? 16'hffff : ((k & 4) ? 16'h8000 : 16'h0000);
      row.yp = (k & 2) ? 16'hffff : ((k & 8) ? 16'h8000 : 16'h0001);
      send_position(row.xp, row.yp, trace_ray(row.xp, row.yp));
    end
    drain();
    write_reg(REG_CORNER, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_RIGHT, {16'h7fff, 16'h7fff, 16'h8000});
    write_reg(REG_UP, {16'h8000, 16'h7fff, 16'h7fff});
    send_position(16'hffff, 16'hffff, trace_ray(16'hffff, 16'hffff));
    send_position(16'h0000, 16'h0000, trace_ray(16'h0000, 16'h0000));
    // Cancelling terms give the zero vector.
    drain();
    write_reg(REG_CORNER, {16'h0000, 16'h0000, 16'h0000});
    write_reg(REG_RIGHT, {16'h0000, 16'h0000, 16'h0001});
    write_reg(REG_UP, {16'h0000, 16'h0000, 16'hffff});
    send_position(16'h4000, 16'h4000, trace_ray(16'h4000, 16'h4000));
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_CORNER, rand_vec(phase % 3));
      write_reg(REG_RIGHT, rand_vec((phase + 1) % 3));
      write_reg(REG_UP, rand_vec(phase % 2));
      for (int n = 0; n < 200; n++) begin
        row.xp = 16'($urandom);
        row.yp = 16'($urandom);
        want = trace_ray(row.xp, row.yp);
        send_position(row.xp, row.yp, want);
      end
      drain();
    end
    sending_done = 1;

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/crd_pkg.sv
design/camera_ray_direction.sv
tb/sv/camera_ray_direction_tb.sv
